[rtl/ps2km_pkg.sv]
// Package for the PS/2 keyboard to key matrix core: operation codes, field
// widths, the matrix port struct and the two ROM keymaps with their lookup.
// No dependencies.
package ps2km_pkg;

    localparam int KM_ENTRIES    = 131;
    localparam int MATRIX_ROWS_D = 15;
    localparam int KEYMAP_LEN_D  = 131;
    localparam int ROW_W         = 4;

    localparam logic [7:0] CODE_RELEASE = 8'hF0;
    localparam logic [7:0] CODE_EXTEND  = 8'hE0;
    localparam logic [7:0] ROW_IDLE     = 8'hFF;
    localparam logic [7:0] NK           = 8'hB7;
    localparam logic [3:0] RX_FRAME_END = 4'd11;
    localparam logic [3:0] TX_ACK_STEP  = 4'd12;
    localparam logic [3:0] TX_PAR_STEP  = 4'd10;
    localparam logic [3:0] TX_LAST_DATA = 4'd9;
    localparam logic [3:0] TX_FIRST_DATA = 4'd2;

    typedef enum logic [1:0] {
        OP_EDGE  = 2'd0,
        OP_START = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_row;
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
        logic [7:0]       wr_data;
    } t_mat_req;

    typedef logic [7:0] t_keymap [0:KM_ENTRIES-1];

    localparam t_keymap KM_A_NORM = '{
        NK, NK, 8'h71, 8'h67, 8'h65, 8'h66, NK, NK,
        NK, NK, NK, 8'h70, 8'h73, NK, NK, NK,
        8'h64, 8'h60, NK, 8'h61, 8'h46, 8'h01, NK, NK,
        NK, 8'h57, 8'h50, 8'h26, 8'h54, 8'h02, NK, NK,
        8'h30, 8'h55, 8'h31, 8'h32, 8'h04, 8'h03, NK, NK,
        8'h80, 8'h53, 8'h33, 8'h51, 8'h47, 8'h05, NK, NK,
        8'h43, 8'h27, 8'h35, 8'h34, 8'h56, 8'h06, NK, NK,
        NK, 8'h42, 8'h37, 8'h52, 8'h07, 8'h10, NK, NK,
        8'h22, 8'h40, 8'h36, 8'h44, 8'h00, 8'h11, NK, NK,
        8'h23, 8'h25, 8'h41, 8'h17, 8'h45, 8'h12, NK, NK,
        8'h24, 8'h20, NK, 8'h15, 8'h13, NK, NK, 8'h63,
        8'h60, 8'h77, 8'h16, NK, 8'h21, NK, NK, NK,
        8'h14, NK, NK, NK, NK, 8'h75, NK, NK,
        8'h01, NK, 8'h04, 8'h07, 8'h23, NK, NK, 8'h00,
        8'h22, 8'h02, 8'h05, 8'h06, 8'h10, 8'h72, NK, NK,
        NK, 8'h03, 8'h12, NK, 8'h11, NK, NK, NK,
        NK, NK, NK
    };

    localparam t_keymap KM_A_EXT = '{
        NK, NK, NK, NK, NK, NK, NK, NK,
        NK, NK, NK, NK, NK, NK, NK, NK,
        8'h62, NK, NK, 8'h42, NK, NK, NK, NK,
        NK, NK, NK, NK, NK, NK, 8'h62, NK,
        NK, NK, NK, NK, NK, NK, 8'h64, NK,
        NK, NK, NK, NK, NK, NK, 8'h80, NK,
        NK, NK, NK, NK, NK, NK, NK, NK,
        NK, NK, NK, NK, NK, NK, NK, NK,
        NK, NK, NK, NK, NK, NK, NK, NK,
        NK, 8'h24, NK, NK, NK, NK, NK, NK,
        NK, NK, NK, NK, NK, NK, NK, NK,
        NK, 8'h77, NK, NK, NK, NK, NK, NK,
        NK, NK, NK, NK, NK, NK, NK, NK,
        NK, NK, 8'h84, 8'h81, NK, NK, NK, 8'h82,
        8'h83, 8'h86, NK, 8'h87, 8'h85, NK, NK, NK,
        NK, 8'h76, NK, NK, 8'h74, NK, NK, NK,
        NK, NK, NK
    };

    localparam t_keymap KM_B_NORM = '{
        NK, NK, 8'h71, 8'h67, 8'h65, 8'h66, NK, NK,
        NK, NK, NK, 8'h70, 8'h73, NK, NK, NK,
        8'h64, 8'h60, NK, 8'h61, 8'h46, 8'h01, NK, NK,
        NK, 8'h57, 8'h50, 8'h26, 8'h54, 8'h02, NK, NK,
        8'h30, 8'h55, 8'h31, 8'h32, 8'h04, 8'h03, NK, NK,
        8'h80, 8'h53, 8'h33, 8'h51, 8'h47, 8'h05, NK, NK,
        8'h43, 8'h27, 8'h35, 8'h34, 8'h56, 8'h06, NK, NK,
        NK, 8'h42, 8'h37, 8'h52, 8'h07, 8'h10, NK, NK,
        8'h22, 8'h40, 8'h36, 8'h44, 8'h00, 8'h11, NK, NK,
        8'h23, 8'h24, 8'h41, 8'h21, 8'h45, 8'h12, NK, NK,
        8'h25, 8'h17, NK, 8'h15, 8'h13, NK, NK, 8'h63,
        8'h60, 8'h77, 8'h16, NK, 8'h21, NK, NK, NK,
        8'h14, NK, NK, NK, NK, 8'h75, NK, NK,
        8'h01, NK, 8'h04, 8'h07, 8'h23, NK, NK, 8'h00,
        8'h22, 8'h02, 8'h05, 8'h06, 8'h10, 8'h72, NK, NK,
        8'h90, 8'h03, 8'h91, 8'h92, 8'h11, NK, NK, NK,
        NK, NK, NK
    };

    localparam t_keymap KM_B_EXT = '{
        NK, NK, NK, NK, NK, NK, NK, NK,
        NK, NK, NK, NK, NK, NK, NK, NK,
        8'h62, NK, NK, 8'h42, NK, NK, NK, NK,
        NK, NK, NK, NK, NK, NK, 8'h62, NK,
        NK, NK, NK, NK, NK, NK, 8'h64, NK,
        NK, NK, NK, NK, NK, NK, 8'h80, NK,
        NK, NK, NK, NK, NK, NK, NK, NK,
        NK, NK, NK, NK, NK, NK, NK, NK,
        NK, NK, NK, NK, NK, NK, NK, NK,
        NK, 8'h94, NK, NK, NK, NK, NK, NK,
        NK, NK, NK, NK, NK, NK, NK, NK,
        NK, 8'h77, NK, NK, NK, NK, NK, NK,
        NK, NK, NK, NK, NK, NK, NK, NK,
        NK, NK, 8'h84, 8'h81, NK, NK, NK, 8'h82,
        8'h83, 8'h86, NK, 8'h87, 8'h85, NK, NK, NK,
        NK, 8'h76, NK, NK, 8'h74, NK, NK, NK,
        NK, NK, NK
    };

    function automatic logic [7:0] keymap_entry(input logic sel, input logic ext,
                                                input logic [7:0] code);
        logic [7:0] idx;
        logic [7:0] entry;
        idx   = code - 8'd1;
        entry = NK;
        if (idx < 8'(KM_ENTRIES)) begin
            case ({sel, ext})
                2'b00:   entry = KM_A_NORM[idx];
                2'b01:   entry = KM_A_EXT[idx];
                2'b10:   entry = KM_B_NORM[idx];
                2'b11:   entry = KM_B_EXT[idx];
                default: entry = NK;
            endcase
        end
        return entry;
    endfunction

endpackage

[rtl/ps2km_matrix.sv]
// Key matrix store: one synchronous row memory with per-row valid bits so
// that unwritten rows read as all ones, plus write-to-read forwarding.
// Depends on ps2km_pkg.
module ps2km_matrix #(
    parameter int MATRIX_ROWS = ps2km_pkg::MATRIX_ROWS_D
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ps2km_pkg::t_mat_req i_req,
    output logic [7:0]          o_rd_data
);

    localparam int IDX_W = $clog2(MATRIX_ROWS);

    logic [7:0]             mem [MATRIX_ROWS];
    logic [MATRIX_ROWS-1:0] r_row_valid;
    logic [7:0]             r_q;
    logic                   r_q_ok;
    logic                   r_fwd;
    logic [7:0]             r_fwd_data;
    logic [IDX_W-1:0]       rd_idx;
    logic [IDX_W-1:0]       wr_idx;

    assign rd_idx = i_req.rd_row[IDX_W-1:0];
    assign wr_idx = i_req.wr_row[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[wr_idx] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_q        <= mem[rd_idx];
            r_fwd_data <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_q_ok      <= 1'b0;
            r_fwd       <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_row_valid[wr_idx] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_q_ok <= r_row_valid[rd_idx];
                r_fwd  <= i_req.wr_en && (wr_idx == rd_idx);
            end
        end
    end

    assign o_rd_data = r_fwd  ? r_fwd_data :
                       r_q_ok ? r_q        : ps2km_pkg::ROW_IDLE;

endmodule

[rtl/ps2_keyboard_to_key_matrix_core.sv]
// PS/2 keyboard host port that keeps an active-low key matrix; top level.
// Depends on ps2km_pkg and ps2km_matrix.
//
// Each input item is one event: a falling keyboard clock edge with the sampled
// data bit, a request to send a command byte, or a read of one matrix row.
// Every item returns exactly one result item. The block takes one item per
// cycle unless a stalled output holds it back; each item passes through the
// s1 stage register and then the output register. The key matrix lives in a
// single row memory with a registered read: a completed scan code reads its
// row when the item is taken and writes the updated row as the item moves on
// to the output register, with forwarding to a read of the same row in that
// cycle. Rows that were never written read as all ones through per-row
// valid bits, so no clearing pass follows reset. Change keymap_select only
// while no item is in flight.
module ps2_keyboard_to_key_matrix_core #(
    parameter int MATRIX_ROWS   = ps2km_pkg::MATRIX_ROWS_D,
    parameter int KEYMAP_LENGTH = ps2km_pkg::KEYMAP_LEN_D
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,  // keymap_select
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,      // data_bit, command_byte[8:1], row_index[12:9]
    input  logic [1:0]  i_s_tuser,      // operation
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata       // data_pull_low, sending, ack_level,
                                        // last_code[10:3], row_bits[18:11]
);

    localparam int RW = ps2km_pkg::ROW_W;

    ps2km_pkg::t_op op;
    logic           in_bit;
    logic [7:0]     in_cmd;
    logic [RW-1:0]  in_row;
    logic           accept;
    logic           s1_move;

    logic           r_keymap_sel;
    logic [7:0]     r_rx_shift,  n_rx_shift;
    logic [3:0]     r_rx_pos,    n_rx_pos;
    logic           r_rel,       n_rel;
    logic           r_ext,       n_ext;
    logic [7:0]     r_last_code, n_last_code;
    logic           r_tx_active, n_tx_active;
    logic [3:0]     r_tx_step,   n_tx_step;
    logic [7:0]     r_tx_shift,  n_tx_shift;
    logic           r_tx_parity, n_tx_parity;
    logic           r_ack,       n_ack;
    logic           n_pull;

    logic           mod_en;
    logic           mod_set;
    logic [RW-1:0]  mod_row;
    logic [2:0]     mod_col;
    logic           rd_req;
    logic [7:0]     entry;

    logic           r_s1_valid;
    logic           r_s1_read;
    logic           r_s1_mod;
    logic           r_s1_set;
    logic [RW-1:0]  r_s1_row;
    logic [2:0]     r_s1_col;
    logic           r_s1_pull;
    logic           r_s1_send;
    logic           r_s1_ack;
    logic [7:0]     r_s1_code;

    logic           r_out_valid;
    logic [23:0]    r_out_data;

    logic [7:0]     row_data;
    logic [7:0]     col_mask;
    ps2km_pkg::t_mat_req mat_req;

    assign op     = ps2km_pkg::t_op'(i_s_tuser);
    assign in_bit = i_s_tdata[0];
    assign in_cmd = i_s_tdata[8:1];
    assign in_row = i_s_tdata[12:9];

    assign s1_move    = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_move;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_rx_shift  = r_rx_shift;
        n_rx_pos    = r_rx_pos;
        n_rel       = r_rel;
        n_ext       = r_ext;
        n_last_code = r_last_code;
        n_tx_active = r_tx_active;
        n_tx_step   = r_tx_step;
        n_tx_shift  = r_tx_shift;
        n_tx_parity = r_tx_parity;
        n_ack       = r_ack;
        mod_en      = 1'b0;
        mod_set     = r_rel;
        entry       = ps2km_pkg::keymap_entry(r_keymap_sel, r_ext, r_rx_shift);
        mod_row     = entry[7:4];
        mod_col     = entry[2:0];
        rd_req      = 1'b0;
        case (op)
            ps2km_pkg::OP_EDGE: begin
                if (r_tx_active) begin
                    n_tx_step = r_tx_step + 4'd1;
                    if (n_tx_step >= ps2km_pkg::TX_ACK_STEP) begin
                        n_ack       = in_bit;
                        n_tx_active = 1'b0;
                    end
                end else begin
                    if (r_rx_pos >= 4'd1 && r_rx_pos <= 4'd8) begin
                        n_rx_shift = r_rx_shift | (8'(in_bit) << 3'(r_rx_pos - 4'd1));
                    end
                    n_rx_pos = r_rx_pos + 4'd1;
                    if (n_rx_pos >= ps2km_pkg::RX_FRAME_END) begin
                        n_last_code = r_rx_shift;
                        n_rx_shift  = '0;
                        n_rx_pos    = '0;
                        if (r_rx_shift == ps2km_pkg::CODE_RELEASE) begin
                            n_rel = 1'b1;
                        end else if (r_rx_shift == ps2km_pkg::CODE_EXTEND) begin
                            n_ext = 1'b1;
                        end else begin
                            n_rel  = 1'b0;
                            n_ext  = 1'b0;
                            mod_en = (r_rx_shift != 8'd0)
                                  && ({1'b0, r_rx_shift} <= 9'(KEYMAP_LENGTH))
                                  && ({1'b0, r_rx_shift} <= 9'(ps2km_pkg::KM_ENTRIES))
                                  && ({1'b0, entry[7:4]} < 5'(MATRIX_ROWS))
                                  && !entry[3];
                        end
                    end
                end
            end
            ps2km_pkg::OP_START: begin
                n_tx_active = 1'b1;
                n_tx_step   = '0;
                n_tx_shift  = in_cmd;
                n_tx_parity = ~^in_cmd;
                n_ack       = 1'b1;
            end
            ps2km_pkg::OP_READ: begin
                rd_req = {1'b0, in_row} < 5'(MATRIX_ROWS);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_pull = 1'b0;
        if (n_tx_active) begin
            if (n_tx_step < ps2km_pkg::TX_FIRST_DATA) begin
                n_pull = 1'b1;
            end else if (n_tx_step <= ps2km_pkg::TX_LAST_DATA) begin
                n_pull = ~n_tx_shift[3'(n_tx_step - ps2km_pkg::TX_FIRST_DATA)];
            end else if (n_tx_step == ps2km_pkg::TX_PAR_STEP) begin
                n_pull = ~n_tx_parity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keymap_sel <= 1'b0;
            r_rx_shift   <= '0;
            r_rx_pos     <= '0;
            r_rel        <= 1'b0;
            r_ext        <= 1'b0;
            r_last_code  <= '0;
            r_tx_active  <= 1'b0;
            r_tx_step    <= '0;
            r_tx_shift   <= '0;
            r_tx_parity  <= 1'b0;
            r_ack        <= 1'b1;
        end else begin
            if (i_cfg_wr_en) begin
                r_keymap_sel <= i_cfg_wr_data;
            end
            if (accept) begin
                r_rx_shift  <= n_rx_shift;
                r_rx_pos    <= n_rx_pos;
                r_rel       <= n_rel;
                r_ext       <= n_ext;
                r_last_code <= n_last_code;
                r_tx_active <= n_tx_active;
                r_tx_step   <= n_tx_step;
                r_tx_shift  <= n_tx_shift;
                r_tx_parity <= n_tx_parity;
                r_ack       <= n_ack;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s1_read   <= 1'b0;
            r_s1_mod    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_s1_read  <= rd_req;
                r_s1_mod   <= mod_en;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
                r_s1_mod   <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_set  <= mod_set;
            r_s1_row  <= mod_row;
            r_s1_col  <= mod_col;
            r_s1_pull <= n_pull;
            r_s1_send <= n_tx_active;
            r_s1_ack  <= n_ack;
            r_s1_code <= n_last_code;
        end
        if (s1_move) begin
            r_out_data <= {5'd0,
                           r_s1_read ? row_data : ps2km_pkg::ROW_IDLE,
                           r_s1_code, r_s1_ack, r_s1_send, r_s1_pull};
        end
    end

    assign col_mask = 8'd1 << r_s1_col;

    always_comb begin
        mat_req.rd_en   = accept && (rd_req || mod_en);
        mat_req.rd_row  = mod_en ? mod_row : in_row;
        mat_req.wr_en   = s1_move && r_s1_mod;
        mat_req.wr_row  = r_s1_row;
        mat_req.wr_data = r_s1_set ? (row_data | col_mask) : (row_data & ~col_mask);
    end

    ps2km_matrix #(
        .MATRIX_ROWS(MATRIX_ROWS)
    ) u_matrix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mat_req),
        .o_rd_data(row_data)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

[rtl/ps2km_checker.sv]
// Port-level checks for the PS/2 keyboard to key matrix core, bound to the
// top level. Depends on ps2_keyboard_to_key_matrix_core.
module ps2km_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result item changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    a_pull_needs_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[1] |-> !o_m_tdata[0])
        else $error("data line pulled low while not sending");

    a_ack_idle_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1] |-> o_m_tdata[2])
        else $error("ack level low during a transmission");

endmodule

bind ps2_keyboard_to_key_matrix_core ps2km_checker u_ps2km_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata)
);

[bench/tb.sv]
// Self-checking bench for ps2_keyboard_to_key_matrix_core: a predictor class mirrors
// the receive, key matrix and send logic and checks each result against it.
// Depends on ps2km_pkg for the operation codes and on the core RTL.
module tb;

    localparam logic [7:0] RELEASE_CODE = 8'hF0;
    localparam logic [7:0] EXTEND_CODE  = 8'hE0;
    localparam logic [7:0] NO_KEY       = 8'hB7;
    localparam int         ROWS         = 15;
    localparam int         MAP_LEN      = 131;
    localparam logic [3:0] FRAME_BITS   = 4'd11;
    localparam logic [3:0] ACK_STEP     = 4'd12;
    localparam int         PHASE_ITEMS  = 385;
    localparam int         LIMIT        = 400000;

    localparam logic [7:0] NORMAL_MAP [0:MAP_LEN-1] = '{
        NO_KEY, NO_KEY, 8'h71, 8'h67, 8'h65, 8'h66, NO_KEY, NO_KEY,
        NO_KEY, NO_KEY, NO_KEY, 8'h70, 8'h73, NO_KEY, NO_KEY, NO_KEY,
        8'h64, 8'h60, NO_KEY, 8'h61, 8'h46, 8'h01, NO_KEY, NO_KEY,
        NO_KEY, 8'h57, 8'h50, 8'h26, 8'h54, 8'h02, NO_KEY, NO_KEY,
        8'h30, 8'h55, 8'h31, 8'h32, 8'h04, 8'h03, NO_KEY, NO_KEY,
        8'h80, 8'h53, 8'h33, 8'h51, 8'h47, 8'h05, NO_KEY, NO_KEY,
        8'h43, 8'h27, 8'h35, 8'h34, 8'h56, 8'h06, NO_KEY, NO_KEY,
        NO_KEY, 8'h42, 8'h37, 8'h52, 8'h07, 8'h10, NO_KEY, NO_KEY,
        8'h22, 8'h40, 8'h36, 8'h44, 8'h00, 8'h11, NO_KEY, NO_KEY,
        8'h23, 8'h25, 8'h41, 8'h17, 8'h45, 8'h12, NO_KEY, NO_KEY,
        8'h24, 8'h20, NO_KEY, 8'h15, 8'h13, NO_KEY, NO_KEY, 8'h63,
        8'h60, 8'h77, 8'h16, NO_KEY, 8'h21, NO_KEY, NO_KEY, NO_KEY,
        8'h14, NO_KEY, NO_KEY, NO_KEY, NO_KEY, 8'h75, NO_KEY, NO_KEY,
        8'h01, NO_KEY, 8'h04, 8'h07, 8'h23, NO_KEY, NO_KEY, 8'h00,
        8'h22, 8'h02, 8'h05, 8'h06, 8'h10, 8'h72, NO_KEY, NO_KEY,
        NO_KEY, 8'h03, 8'h12, NO_KEY, 8'h11, NO_KEY, NO_KEY, NO_KEY,
        NO_KEY, NO_KEY, NO_KEY
    };

    typedef struct packed {
        logic [7:0] row_bits;
        logic [7:0] last_code;
        logic       ack_level;
        logic       sending;
        logic       pull_low;
    } t_kbd_result;

    class t_key_matrix_mirror;
        logic [7:0]  rx_shift;
        logic [3:0]  rx_pos;
        logic        rel_mark;
        logic        ext_mark;
        logic [7:0]  last_code;
        logic [7:0]  rows [ROWS];
        logic        tx_active;
        logic [3:0]  tx_step;
        logic [7:0]  tx_byte;
        logic        tx_par;
        logic        ack;
        logic        layout;
        t_kbd_result pending_results [$];
        int          errors;

        function new();
            rx_shift  = '0;
            rx_pos    = '0;
            rel_mark  = 1'b0;
            ext_mark  = 1'b0;
            last_code = '0;
            foreach (rows[i]) rows[i] = 8'hFF;
            tx_active = 1'b0;
            tx_step   = '0;
            tx_byte   = '0;
            tx_par    = 1'b0;
            ack       = 1'b1;
            layout    = 1'b0;
            errors    = 0;
        endfunction

        function logic [7:0] map_entry(logic ext_sel, logic [7:0] code);
            int idx;
            logic [7:0] e;
            idx = int'(code) - 1;
            e = NO_KEY;
            if (!ext_sel) begin
                e = NORMAL_MAP[idx];
                if (layout) begin
                    case (idx)
                        73:  e = 8'h24;
                        75:  e = 8'h21;
                        80:  e = 8'h25;
                        81:  e = 8'h17;
                        120: e = 8'h90;
                        122: e = 8'h91;
                        123: e = 8'h92;
                        default: ;
                    endcase
                end
            end else begin
                case (idx)
                    16, 30:  e = 8'h62;
                    19:      e = 8'h42;
                    38:      e = 8'h64;
                    46:      e = 8'h80;
                    73:      e = layout ? 8'h94 : 8'h24;
                    89:      e = 8'h77;
                    106:     e = 8'h84;
                    107:     e = 8'h81;
                    111:     e = 8'h82;
                    112:     e = 8'h83;
                    113:     e = 8'h86;
                    115:     e = 8'h87;
                    116:     e = 8'h85;
                    121:     e = 8'h76;
                    124:     e = 8'h74;
                    default: e = NO_KEY;
                endcase
            end
            return e;
        endfunction

        function void apply_code(logic [7:0] code);
            logic [7:0] e;
            logic [3:0] r;
            logic [3:0] c;
            logic       was_rel;
            logic       was_ext;
            was_rel  = rel_mark;
            was_ext  = ext_mark;
            rel_mark = 1'b0;
            ext_mark = 1'b0;
            if (code == 8'd0 || int'(code) > MAP_LEN) return;
            e = map_entry(was_ext, code);
            r = e[7:4];
            c = e[3:0];
            if (int'(r) >= ROWS || c > 4'd7) return;
            rows[r][c[2:0]] = was_rel;
        endfunction

        function void clock_edge(logic dbit);
            if (tx_active) begin
                tx_step = tx_step + 4'd1;
                if (tx_step >= ACK_STEP) begin
                    ack       = dbit;
                    tx_active = 1'b0;
                end
                return;
            end
            if (rx_pos >= 4'd1 && rx_pos <= 4'd8)
                rx_shift = rx_shift | (8'(dbit) << (rx_pos - 4'd1));
            rx_pos = rx_pos + 4'd1;
            if (rx_pos >= FRAME_BITS) begin
                if (rx_shift == RELEASE_CODE)
                    rel_mark = 1'b1;
                else if (rx_shift == EXTEND_CODE)
                    ext_mark = 1'b1;
                else
                    apply_code(rx_shift);
                last_code = rx_shift;
                rx_shift  = '0;
                rx_pos    = '0;
            end
        endfunction

        function logic line_pull();
            if (!tx_active) return 1'b0;
            if (tx_step <= 4'd1) return 1'b1;
            if (tx_step <= 4'd9) return ~tx_byte[tx_step - 4'd2];
            if (tx_step == 4'd10) return ~tx_par;
            return 1'b0;
        endfunction

        function void take_event(ps2km_pkg::t_op op, logic dbit, logic [7:0] cmd,
                                 logic [3:0] row_sel);
            t_kbd_result r;
            logic [7:0]  rb;
            rb = 8'hFF;
            case (op)
                ps2km_pkg::OP_EDGE: clock_edge(dbit);
                ps2km_pkg::OP_START: begin
                    tx_active = 1'b1;
                    tx_step   = '0;
                    tx_byte   = cmd;
                    tx_par    = ~^cmd;
                    ack       = 1'b1;
                end
                ps2km_pkg::OP_READ: begin
                    if (int'(row_sel) < ROWS) rb = rows[row_sel];
                end
                default: ;
            endcase
            r.pull_low  = line_pull();
            r.sending   = tx_active;
            r.ack_level = ack;
            r.last_code = last_code;
            r.row_bits  = rb;
            pending_results.push_back(r);
        endfunction

        function void report_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void match_result(logic [23:0] d);
            t_kbd_result want;
            t_kbd_result got;
            got = d[18:0];
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, expected none, actual %0h", $time, d);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            report_field("data_pull_low", want.pull_low, got.pull_low);
            report_field("sending", want.sending, got.sending);
            report_field("ack_level", want.ack_level, got.ack_level);
            report_field("last_code", want.last_code, got.last_code);
            report_field("row_bits", want.row_bits, got.row_bits);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata = '0;     // data_bit, command_byte[8:1], row_index[12:9]
    logic [1:0]  i_s_tuser = '0;     // operation
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;         // data_pull_low, sending, ack_level,
                                    // last_code[10:3], row_bits[18:11]

    t_key_matrix_mirror mirror;
    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int cycles = 0;

    ps2_keyboard_to_key_matrix_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) mirror.match_result(o_m_tdata);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic push_item(ps2km_pkg::t_op op, logic dbit, logic [7:0] cmd,
                             logic [3:0] row_sel);
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {3'b000, row_sel, cmd, dbit};
        do @(posedge i_clk); while (!o_s_tready);
        mirror.take_event(op, dbit, cmd, row_sel);
        items_sent++;
    endtask

    task automatic push_edge(logic dbit);
        push_item(ps2km_pkg::OP_EDGE, dbit, 8'($urandom), 4'($urandom));
    endtask

    task automatic send_frame(logic [7:0] code);
        push_edge(1'b0);
        for (int i = 0; i < 8; i++) push_edge(code[i]);
        push_edge(~^code);
        push_edge(1'b1);
    endtask

    // finish any send in progress and realign the receiver to a frame boundary
    task automatic settle_line();
        while (mirror.tx_active) push_edge(1'($urandom_range(1)));
        while (mirror.rx_pos != 4'd0) push_edge(1'($urandom_range(1)));
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (mirror.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_keymap(logic sel);
        drain_results();
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= sel;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        mirror.layout = sel;
    endtask

    function automatic logic [7:0] pick_code();
        int p;
        p = $urandom_range(19);
        if (p == 0) return 8'd0;
        if (p == 1) return 8'($urandom_range(255, MAP_LEN + 1));
        return 8'($urandom_range(MAP_LEN, 1));
    endfunction

    task automatic run_random(int count);
        int stop_at;
        int pick;
        int n;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                settle_line();
                if ($urandom_range(3) == 0) send_frame(EXTEND_CODE);
                if ($urandom_range(9) < 4) send_frame(RELEASE_CODE);
                send_frame(pick_code());
            end else if (pick < 65) begin
                push_item(ps2km_pkg::OP_READ, 1'($urandom_range(1)), 8'($urandom),
                          4'($urandom_range(15)));
            end else if (pick < 80) begin
                push_item(ps2km_pkg::OP_START, 1'($urandom_range(1)), 8'($urandom),
                          4'($urandom));
                n = ($urandom_range(9) < 8) ? 12 : $urandom_range(11);
                repeat (n) push_edge(1'($urandom_range(1)));
            end else if (pick < 88) begin
                for (int r = 0; r < ROWS; r += $urandom_range(4, 1))
                    push_item(ps2km_pkg::OP_READ, 1'($urandom_range(1)), 8'($urandom),
                              4'(r));
            end else if (pick < 95) begin
                repeat ($urandom_range(3, 1)) push_edge(1'($urandom_range(1)));
            end else begin
                push_item(ps2km_pkg::OP_NONE, 1'($urandom_range(1)), 8'($urandom),
                          4'($urandom));
            end
        end
    endtask

    initial begin
        mirror = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_item(ps2km_pkg::OP_READ, 1'b0, 8'h00, 4'd0);
        push_item(ps2km_pkg::OP_READ, 1'b1, 8'hFF, 4'd14);
        push_item(ps2km_pkg::OP_READ, 1'b0, 8'h00, 4'd15);
        push_item(ps2km_pkg::OP_NONE, 1'b1, 8'hFF, 4'hF);
        push_edge(1'b0);
        push_edge(1'b1);
        push_edge(1'b1);
        push_item(ps2km_pkg::OP_START, 1'b0, 8'hFF, 4'd0);
        push_edge(1'b1);
        push_edge(1'b0);
        push_item(ps2km_pkg::OP_START, 1'b1, 8'h00, 4'd0);
        repeat (11) push_edge(1'b1);
        push_edge(1'b0);

        write_keymap(1'b1);
        idle_pct  = 0;
        stall_pct = 0;
        run_random(PHASE_ITEMS);

        write_keymap(1'b0);
        idle_pct  = 64;
        stall_pct = 0;
        run_random(PHASE_ITEMS / 2);
        drain_results();
        run_random(PHASE_ITEMS / 2);

        write_keymap(1'b1);
        idle_pct  = 0;
        stall_pct = 64;
        run_random(PHASE_ITEMS);

        write_keymap(1'b0);
        idle_pct  = 6;
        stall_pct = 6;
        run_random(PHASE_ITEMS);

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mirror.errors == 0 && mirror.pending_results.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
